[rtl/core/lmcfw_pkg.sv]
// Shared types and constants for the LED matrix chain frame writer.
`default_nettype none

package lmcfw_pkg;

	// Command codes carried in the opcode field.
	typedef enum logic [1:0] {
		OP_RAW   = 2'd0,
		OP_LED   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	// One command beat.
	typedef struct packed {
		logic [1:0] opcode;
		logic [2:0] device;
		logic [7:0] reg_addr;
		logic [7:0] reg_data;
		logic [3:0] row;
		logic [3:0] col;
		logic       led_on;
	} in_t;

	// One serial byte beat.
	typedef struct packed {
		logic [7:0] spi_byte;
		logic       frame_end;
		logic       last;
	} out_t;

	// Column 0 maps to the most significant bit of a row.
	localparam logic [7:0] COL0_MASK = 8'h80;
	// Register and data byte sent to devices that are not addressed.
	localparam logic [7:0] NOOP_BYTE = 8'h00;
	// Highest valid row or column.
	localparam logic [3:0] MAX_RC    = 4'd7;
	// Rows per device.
	localparam int unsigned ROWS     = 8;

endpackage : lmcfw_pkg

`default_nettype wire

[rtl/core/lmcfw_shadow.sv]
// Row shadow store: one byte per device row, cleared by reset.
`default_nettype none

module lmcfw_shadow import lmcfw_pkg::*; #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned IDX_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire logic [7:0]       wr_data,
	input  wire logic [IDX_W-1:0] rd_idx,
	output      logic [7:0]       rd_data
);

	logic [7:0] rows_q [DEPTH];

	// Entries are plain registers so that reset clears the whole shadow at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				rows_q[i] <= NOOP_BYTE;
			end
		end else if (wr_en) begin
			rows_q[wr_idx] <= wr_data;
		end
	end

	// Read at one address for the read-modify-write of a row.
	assign rd_data = rows_q[rd_idx];

endmodule : lmcfw_shadow

`default_nettype wire

[rtl/core/led_matrix_chain_frame_writer.sv]
// Top level: command sequencer that turns commands into chain frames of serial bytes.
// Flow: a command is accepted in ST_IDLE, prepared in ST_PREP, then sent one byte per cycle while out_ready is high.
// A frame is 2*CHAIN_DEVICES bytes; a clear command sends 8 frames (16*CHAIN_DEVICES bytes).
// The single byte selector walks device positions one byte at a time, and a new command is
// accepted only once the last byte of the previous command has been loaded.
// Reset: arst_n clears the sequencer, the output valid flag and every shadow row at once.
`default_nettype none

module led_matrix_chain_frame_writer import lmcfw_pkg::*; #(
	parameter int unsigned CHAIN_DEVICES = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output      logic in_ready,
	input  wire in_t  in_data,
	output      logic out_valid,
	input  wire logic out_ready,
	output      out_t out_data
);

	localparam int unsigned DEPTH = CHAIN_DEVICES * ROWS;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned POS_W = (CHAIN_DEVICES > 1) ? $clog2(CHAIN_DEVICES) : 1;
	localparam logic [2:0]  CHAIN_LIMIT = 3'(CHAIN_DEVICES);
	localparam logic [POS_W-1:0] POS_FAR = POS_W'(CHAIN_DEVICES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_EMIT
	} state_t;

	state_t          state_q;
	op_t             op_q;
	logic [2:0]      dev_q;
	logic [2:0]      row_q;
	logic [2:0]      col_q;
	logic            led_q;
	logic [7:0]      reg_q;
	logic [7:0]      data_q;
	logic [POS_W-1:0] pos_q;
	logic            half_q;
	logic [2:0]      frame_q;
	logic            out_valid_q;
	out_t            out_q;

	logic            cmd_ok;
	logic            load;
	logic            target;
	logic            frame_done;
	logic            cmd_done;
	logic [7:0]      next_byte;
	logic [7:0]      led_mask;
	logic [7:0]      rmw_row;
	logic [2:0]      wr_row;
	logic [5:0]      wr_full_idx;
	logic [5:0]      rd_full_idx;
	logic            sh_wr_en;
	logic [7:0]      sh_wr_data;
	logic [7:0]      sh_rd_data;

	// Decide whether an incoming command produces any bytes.
	always_comb begin
		cmd_ok = 1'b0;
		if (in_data.device < CHAIN_LIMIT) begin
			case (in_data.opcode)
				OP_RAW:   cmd_ok = 1'b1;
				OP_LED:   cmd_ok = (in_data.row <= MAX_RC) && (in_data.col <= MAX_RC);
				OP_CLEAR: cmd_ok = 1'b1;
				default:  cmd_ok = 1'b0;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// Read-modify-write of the addressed row for an LED set or clear command.
	assign led_mask    = COL0_MASK >> col_q;
	assign rd_full_idx = {dev_q, row_q};
	assign rmw_row     = led_q ? (sh_rd_data | led_mask) : (sh_rd_data & ~led_mask);

	// Shared byte selector: the addressed position gets the real pair, others a no-op.
	assign target     = (3'(pos_q) == dev_q);
	assign next_byte  = target ? (half_q ? data_q : reg_q) : NOOP_BYTE;
	assign frame_done = half_q && (pos_q == '0);
	assign cmd_done   = frame_done && ((op_q != OP_CLEAR) || (frame_q == 3'(ROWS - 1)));
	assign load       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// Shadow writes: the updated row in the prepare cycle, or zero at each clear frame start.
	always_comb begin
		sh_wr_en   = 1'b0;
		sh_wr_data = NOOP_BYTE;
		wr_row     = row_q;
		if (state_q == ST_PREP) begin
			if (op_q == OP_LED) begin
				sh_wr_en   = 1'b1;
				sh_wr_data = rmw_row;
			end else if (op_q == OP_CLEAR) begin
				sh_wr_en = 1'b1;
				wr_row   = '0;
			end
		end else if (load && frame_done && !cmd_done) begin
			sh_wr_en = 1'b1;
			wr_row   = frame_q + 3'd1;
		end
	end
	assign wr_full_idx = {dev_q, wr_row};

	lmcfw_shadow #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_shadow (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (sh_wr_en),
		.wr_idx  (wr_full_idx[IDX_W-1:0]),
		.wr_data (sh_wr_data),
		.rd_idx  (rd_full_idx[IDX_W-1:0]),
		.rd_data (sh_rd_data)
	);

	// Sequencer state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// The output register fills on a load and empties once its beat is taken.
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && cmd_ok) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (load && cmd_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command and walk registers; payload only, no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q   <= op_t'(in_data.opcode);
				dev_q  <= in_data.device;
				row_q  <= in_data.row[2:0];
				col_q  <= in_data.col[2:0];
				led_q  <= in_data.led_on;
				reg_q  <= in_data.reg_addr;
				data_q <= in_data.reg_data;
			end
			ST_PREP: begin
				pos_q   <= POS_FAR;
				half_q  <= 1'b0;
				frame_q <= '0;
				if (op_q == OP_LED) begin
					reg_q  <= 8'(row_q) + 8'd1;
					data_q <= rmw_row;
				end else if (op_q == OP_CLEAR) begin
					reg_q  <= 8'd1;
					data_q <= NOOP_BYTE;
				end
			end
			ST_EMIT: begin
				if (load) begin
					out_q.spi_byte  <= next_byte;
					out_q.frame_end <= frame_done;
					out_q.last      <= cmd_done;
					if (!half_q) begin
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						if (pos_q == '0) begin
							pos_q   <= POS_FAR;
							frame_q <= frame_q + 3'd1;
							reg_q   <= 8'(frame_q) + 8'd2;
						end else begin
							pos_q <= pos_q - POS_W'(1);
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The last byte of a command always closes a frame.
	a_last_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> out_data.frame_end)
		else $error("last byte without frame end");

	// A command for a device beyond the chain starts no work.
	a_out_of_chain_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.device >= CHAIN_LIMIT) |=> state_q == ST_IDLE)
		else $error("out-of-chain command started a sequence");

	// A frame end that is not the last byte leaves the sequencer emitting.
	a_more_frames_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end && !out_data.last |-> state_q == ST_EMIT)
		else $error("sequencer left emit before the final frame");

endmodule : led_matrix_chain_frame_writer

`default_nettype wire

[tb/lmcfw_frame_checker.sv]
// Checker that predicts chain frames from command beats and compares them with the serial byte beats.
module lmcfw_frame_checker import lmcfw_pkg::*; #(
	parameter int unsigned CHAIN_DEVICES = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_data,
	output int   fail_count,
	output int   expected_left,
	output int   beat_count,
	output int   frame_count
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted copy of every device's display rows, entry device*8+row.
	logic [7:0] shadow_rows [32];
	// Serial bytes predicted but not yet seen, oldest first.
	out_t       byte_queue [$];
	out_t       want;

	// Queue one chain frame, farthest device first, no-op pairs for the others.
	task automatic queue_frame(input int unsigned dev, input logic [7:0] reg_byte,
			input logic [7:0] data_byte);
		out_t b;
		for (int pos = CHAIN_DEVICES - 1; pos >= 0; pos--) begin
			b.spi_byte  = (pos == dev) ? reg_byte : NOOP_BYTE;
			b.frame_end = 1'b0;
			b.last      = 1'b0;
			byte_queue.push_back(b);
			b.spi_byte  = (pos == dev) ? data_byte : NOOP_BYTE;
			b.frame_end = (pos == 0);
			byte_queue.push_back(b);
		end
	endtask

	// Work out the bytes that one command produces and update the row shadow.
	task automatic predict_cmd(input in_t c);
		int         first;
		int         idx;
		logic [7:0] mask;
		out_t       tail;
		first = byte_queue.size();
		if (c.device < CHAIN_DEVICES) begin
			case (op_t'(c.opcode))
				OP_RAW: begin
					// Raw writes bypass the shadow, even for digit registers.
					queue_frame(c.device, c.reg_addr, c.reg_data);
				end
				OP_LED: begin
					if (c.row <= MAX_RC && c.col <= MAX_RC) begin
						idx = int'(c.device) * ROWS + int'(c.row);
						mask = COL0_MASK >> c.col;
						if (c.led_on)
							shadow_rows[idx] = shadow_rows[idx] | mask;
						else
							shadow_rows[idx] = shadow_rows[idx] & ~mask;
						queue_frame(c.device, 8'(c.row) + 8'd1, shadow_rows[idx]);
					end
				end
				OP_CLEAR: begin
					for (int r = 0; r < ROWS; r++) begin
						shadow_rows[int'(c.device) * ROWS + r] = 8'h00;
						queue_frame(c.device, 8'(r + 1), 8'h00);
					end
				end
				default: begin
				end
			endcase
		end
		// Mark the final byte of this command.
		if (byte_queue.size() > first) begin
			tail = byte_queue.pop_back();
			tail.last = 1'b1;
			byte_queue.push_back(tail);
		end
	endtask

	// Compare accepted serial bytes with the oldest prediction, then take in new commands.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_rows[i]) shadow_rows[i] = 8'h00;
			byte_queue.delete();
			fail_count    = 0;
			expected_left = 0;
			beat_count    = 0;
			frame_count   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (byte_queue.size() == 0) begin
					$error("Unexpected serial byte beat: spi_byte 0x%02h", out_data.spi_byte);
					fail_count++;
				end else begin
					want = byte_queue.pop_front();
					beat_count++;
					if (want.frame_end)
						frame_count++;
					if (out_data.spi_byte !== want.spi_byte) begin
						$error("spi_byte mismatch: expected 0x%02h, actual 0x%02h",
							want.spi_byte, out_data.spi_byte);
						fail_count++;
					end
					if (out_data.frame_end !== want.frame_end) begin
						$error("frame_end mismatch: expected %0b, actual %0b",
							want.frame_end, out_data.frame_end);
						fail_count++;
					end
					if (out_data.last !== want.last) begin
						$error("last mismatch: expected %0b, actual %0b",
							want.last, out_data.last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_cmd(in_data);
			expected_left = byte_queue.size();
		end
	end

endmodule : lmcfw_frame_checker

[tb/tb_top.sv]
// Testbench top: clock, reset, command stimulus, serial back-pressure and the verdict.
module tb_top import lmcfw_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CHAIN_DEVICES = 4;
	localparam int CYCLE_LIMIT   = 1_500_000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int IN_W          = $bits(in_t);

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	in_t  in_data   = '0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	out_t out_data;

	int mismatch_total;
	int bytes_outstanding;
	int beats_checked;
	int frames_checked;

	// Quiet phase with no idling on either side, and a request for a long receiver hold-off.
	bit calm     = 1'b0;
	bit hold_req = 1'b0;
	int cycle_count = 0;
	int op_sent [4];
	int silent_sent = 0;

	led_matrix_chain_frame_writer #(
		.CHAIN_DEVICES(CHAIN_DEVICES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	lmcfw_frame_checker #(
		.CHAIN_DEVICES(CHAIN_DEVICES)
	) u_frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (mismatch_total),
		.expected_left(bytes_outstanding),
		.beat_count   (beats_checked),
		.frame_count  (frames_checked)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run-length guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL led_matrix_chain_frame_writer");
			$finish;
		end
	end

	// True when a command should produce at least one serial byte.
	function automatic bit has_output(input in_t c);
		if (c.device >= CHAIN_DEVICES)
			return 1'b0;
		case (op_t'(c.opcode))
			OP_RAW, OP_CLEAR: return 1'b1;
			OP_LED:           return (c.row <= MAX_RC) && (c.col <= MAX_RC);
			default:          return 1'b0;
		endcase
	endfunction

	// Build a command; fields the opcode ignores carry random junk.
	function automatic in_t make_cmd(input op_t op, input logic [2:0] dev,
			input logic [7:0] ra, input logic [7:0] rd, input logic [3:0] row,
			input logic [3:0] col, input logic on);
		in_t c;
		c = IN_W'($urandom);
		c.opcode = op;
		c.device = dev;
		if (op == OP_RAW) begin
			c.reg_addr = ra;
			c.reg_data = rd;
		end
		if (op == OP_LED) begin
			c.row    = row;
			c.col    = col;
			c.led_on = on;
		end
		return c;
	endfunction

	// Random command, mostly LED edits on devices in the chain, with some noise.
	function automatic in_t rand_cmd();
		in_t c;
		int  pick;
		c = IN_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55)
			c.opcode = OP_LED;
		else if (pick < 82)
			c.opcode = OP_RAW;
		else if (pick < 91)
			c.opcode = OP_CLEAR;
		else
			c.opcode = OP_RSVD;
		if ($urandom_range(0, 9) < 9)
			c.device = 3'($urandom_range(0, CHAIN_DEVICES - 1));
		if ($urandom_range(0, 9) < 9) begin
			c.row[3] = 1'b0;
			c.col[3] = 1'b0;
		end
		c.led_on = ($urandom_range(0, 9) < 7);
		return c;
	endfunction

	// Offer one command beat, hold it until accepted, then maybe idle for a burst.
	task automatic send_cmd(input in_t c);
		in_data  <= c;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		op_sent[c.opcode]++;
		if (!has_output(c))
			silent_sent++;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
	endtask

	// Random commands until the given number of them have produced output.
	task automatic run_random(input int count);
		int   done;
		in_t  c;
		done = 0;
		while (done < count) begin
			c = rand_cmd();
			send_cmd(c);
			if (has_output(c))
				done++;
		end
	endtask

	// Stop offering and wait until every predicted byte has come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (bytes_outstanding != 0)
			@(negedge clk);
	endtask

	// Serial receiver: random stall bursts, a long hold-off on request, none when calm.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 14)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Command stimulus and verdict.
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Raw writes at byte extremes and to a digit register, which leaves the shadow alone.
		send_cmd(make_cmd(OP_RAW, 3'd0, 8'hFF, 8'h00, 4'd0, 4'd0, 1'b0));
		send_cmd(make_cmd(OP_RAW, 3'd3, 8'h00, 8'hFF, 4'd0, 4'd0, 1'b0));
		send_cmd(make_cmd(OP_RAW, 3'd1, 8'h01, 8'hAA, 4'd0, 4'd0, 1'b0));
		send_cmd(make_cmd(OP_LED, 3'd1, 8'h00, 8'h00, 4'd0, 4'd7, 1'b1));
		// LED edits at the corner columns and rows and one interior LED, set and clear.
		send_cmd(make_cmd(OP_LED, 3'd0, 8'h00, 8'h00, 4'd0, 4'd0, 1'b1));
		send_cmd(make_cmd(OP_LED, 3'd3, 8'h00, 8'h00, 4'd7, 4'd7, 1'b1));
		send_cmd(make_cmd(OP_LED, 3'd3, 8'h00, 8'h00, 4'd7, 4'd0, 1'b1));
		send_cmd(make_cmd(OP_LED, 3'd3, 8'h00, 8'h00, 4'd7, 4'd7, 1'b0));
		send_cmd(make_cmd(OP_LED, 3'd1, 8'h00, 8'h00, 4'd4, 4'd2, 1'b0));
		// Rows and columns out of range.
		send_cmd(make_cmd(OP_LED, 3'd2, 8'h00, 8'h00, 4'd8, 4'd0, 1'b1));
		send_cmd(make_cmd(OP_LED, 3'd2, 8'h00, 8'h00, 4'd15, 4'd15, 1'b1));
		send_cmd(make_cmd(OP_LED, 3'd2, 8'h00, 8'h00, 4'd3, 4'd8, 1'b1));
		send_cmd(make_cmd(OP_LED, 3'd2, 8'h00, 8'h00, 4'd0, 4'd15, 1'b0));
		// Devices beyond the end of the chain.
		send_cmd(make_cmd(OP_RAW, 3'd4, 8'h0F, 8'hF0, 4'd0, 4'd0, 1'b0));
		send_cmd(make_cmd(OP_LED, 3'd7, 8'h00, 8'h00, 4'd0, 4'd0, 1'b1));
		send_cmd(make_cmd(OP_CLEAR, 3'd5, 8'h00, 8'h00, 4'd0, 4'd0, 1'b0));
		// Clear a device with lit LEDs, then edit it again from a blank row.
		send_cmd(make_cmd(OP_CLEAR, 3'd3, 8'h00, 8'h00, 4'd0, 4'd0, 1'b0));
		send_cmd(make_cmd(OP_LED, 3'd3, 8'h00, 8'h00, 4'd7, 4'd3, 1'b1));
		// Reserved opcode, then more raw traffic and a clear of device zero.
		send_cmd(make_cmd(OP_RSVD, 3'd0, 8'h12, 8'h34, 4'd1, 4'd1, 1'b1));
		send_cmd(make_cmd(OP_RAW, 3'd2, 8'h55, 8'h5A, 4'd0, 4'd0, 1'b0));
		send_cmd(make_cmd(OP_CLEAR, 3'd0, 8'h00, 8'h00, 4'd0, 4'd0, 1'b0));
		send_cmd(make_cmd(OP_LED, 3'd0, 8'h00, 8'h00, 4'd0, 4'd0, 1'b1));

		// Random traffic with idling on both sides.
		run_random(110);

		// Long serial hold-off while commands keep coming, so the input stalls.
		hold_req = 1'b1;
		repeat (24) send_cmd(rand_cmd());
		wait_idle();

		run_random(65);

		// Closing stretch at full rate on both sides.
		calm = 1'b1;
		run_random(30);

		wait_idle();
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Sent %0d raw, %0d LED, %0d clear and %0d reserved commands; %0d gave no output.",
			op_sent[OP_RAW], op_sent[OP_LED], op_sent[OP_CLEAR], op_sent[OP_RSVD], silent_sent);
		$display("Checked %0d serial bytes in %0d chain frames, including a long receiver stall.",
			beats_checked, frames_checked);
		if (mismatch_total == 0)
			$display("PASS led_matrix_chain_frame_writer");
		else
			$display("FAIL led_matrix_chain_frame_writer");
		$finish;
	end

endmodule : tb_top
